/* hw/rtl/uwe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uwe_pkg
// Shared constants, types and helper functions of the unique word extractor.
// ----------------------------------------------------------------------------
package uwe_pkg;

	localparam int WORD_LEN    = 256;
	localparam int TABLE_WORDS = 8192;
	localparam int TITLE_MAX   = 1024;
	localparam int MAX_RES     = 32;

	localparam int CHUNK_BYTES = 8;
	localparam int CHUNK_W     = 8 * CHUNK_BYTES;
	localparam int ROWS        = WORD_LEN / CHUNK_BYTES;
	localparam int ROW_W       = $clog2(ROWS);
	localparam int LEN_W       = $clog2(WORD_LEN);
	localparam int IDX_W       = $clog2(TABLE_WORDS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int TITLE_W     = $clog2(TITLE_MAX);
	localparam int RES_W       = $clog2(MAX_RES + 1);
	localparam int STORE_ROWS  = TABLE_WORDS * ROWS;
	localparam int NB_W        = 4;

	localparam logic [7:0] BYTE_APOS = 8'h27;
	localparam logic [7:0] BYTE_NL   = 8'h0A;
	localparam logic [7:0] UTF_LEAD  = 8'hE2;
	localparam logic [7:0] UTF_MID   = 8'h80;
	localparam logic [7:0] UTF_END   = 8'h99;

	localparam logic KIND_TITLE = 1'b0;
	localparam logic KIND_WORD  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [CHUNK_W-1:0] chunk;
		logic [NB_W-1:0]    nbytes;
		logic [IDX_W-1:0]   idx;
	} emit_req_t;

	typedef struct packed {
		logic             wr;
		logic [7:0]       ch;
		logic             clear;
		logic [ROW_W-1:0] row;
	} wb_cmd_t;

	typedef struct packed {
		logic             nonempty;
		logic [LEN_W-1:0] wlen;
	} wb_stat_t;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [ROW_W-1:0]   row;
		logic               row_we;
		logic [CHUNK_W-1:0] row_data;
		logic               len_we;
		logic [LEN_W-1:0]   len;
	} tbl_req_t;

	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == BYTE_APOS;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	function automatic logic [CHUNK_W-1:0] byte_mask(input logic [NB_W-1:0] n);
		logic [CHUNK_W-1:0] m;
		m = '0;
		for (int k = 0; k < CHUNK_BYTES; k++) begin
			if (NB_W'(k) < n) begin
				m[8*k +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/unique_word_extractor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// unique_word_extractor
// Text tokenizer that passes the title line through and emits each distinct
// word once, in 8-byte chunks, together with its table position.
// ----------------------------------------------------------------------------
// One byte is taken per input transfer; the input stalls while the byte is
// worked off. A byte that ends a word starts a search of the word table,
// which has one port: the length of each stored word is read and compared,
// then each 8-byte row is compared where the lengths agree, and then each
// chunk of a new word is copied in and sent out. The search time therefore
// grows with the number of stored words. The table needs no clearing after
// reset or after the end of a text: only entries below the stored word count
// are ever read. Output stalls hold back the engine only when results are
// waiting.
module unique_word_extractor (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [7:0]              text_byte,
	input  wire logic                    end_of_text,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         kind,
	output logic [uwe_pkg::CHUNK_W-1:0]  chunk,
	output logic [uwe_pkg::NB_W-1:0]     chunk_bytes,
	output logic [uwe_pkg::IDX_W-1:0]    word_index,
	output logic                         last_of_run
);
	import uwe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHAR, S_END, S_RESET, S_FLUSH, S_FIN, S_FIN_DONE,
		S_LEN_RD, S_LEN_CHK, S_ROW_RD, S_ROW_CHK, S_INS, S_CP_RD, S_CP_EMIT
	} state_t;

	state_t            state_q;
	logic              phase_q;
	logic [1:0]        pc_q;
	logic [TITLE_W-1:0] tc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  widx_q;
	logic [ROW_W-1:0]  row_q;
	logic [7:0]        chars_q [4];
	logic [1:0]        nch_q;
	logic [1:0]        ci_q;
	logic              last_q;
	logic              fin_end_q;

	logic [7:0]        ch_n [4];
	logic [1:0]        n_n;
	logic [1:0]        pc_n;
	logic              accept;

	logic              emit_v;
	emit_req_t         emit_req;
	logic              emit_ready;
	logic              flush;
	logic              flush_ready;
	wb_cmd_t           wb_cmd;
	wb_stat_t          wb_stat;
	logic [CHUNK_W-1:0] wb_rd;
	tbl_req_t          tbl_req;
	logic [CHUNK_W-1:0] tbl_row;
	logic [LEN_W-1:0]  tbl_len;

	logic [7:0]        cur;
	logic              title_room;
	logic [LEN_W-1:0]  wlen_m1;
	logic              last_row;
	logic [NB_W-1:0]   nb;
	logic [CHUNK_W-1:0] mask;
	logic              row_eq;
	logic              ins_phase;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// expand the byte and any held quote bytes into up to three characters
	always_comb begin
		ch_n = '{default: 8'h00};
		n_n  = 2'd0;
		pc_n = pc_q;
		if (pc_q == 2'd2 && text_byte == UTF_END) begin
			ch_n[0] = BYTE_APOS;
			n_n     = 2'd1;
			pc_n    = 2'd0;
		end else if (pc_q == 2'd1 && text_byte == UTF_MID) begin
			pc_n = 2'd2;
		end else begin
			if (pc_q >= 2'd1) begin
				ch_n[n_n] = UTF_LEAD;
				n_n       = n_n + 1'b1;
			end
			if (pc_q >= 2'd2) begin
				ch_n[n_n] = UTF_MID;
				n_n       = n_n + 1'b1;
			end
			if (text_byte == UTF_LEAD) begin
				pc_n = 2'd1;
			end else begin
				pc_n      = 2'd0;
				ch_n[n_n] = text_byte;
				n_n       = n_n + 1'b1;
			end
		end
		if (end_of_text) begin
			if (pc_n >= 2'd1) begin
				ch_n[n_n] = UTF_LEAD;
				n_n       = n_n + 1'b1;
			end
			if (pc_n >= 2'd2) begin
				ch_n[n_n] = UTF_MID;
				n_n       = n_n + 1'b1;
			end
			pc_n = 2'd0;
		end
	end

	assign cur        = chars_q[ci_q];
	assign title_room = (tc_q != TITLE_W'(TITLE_MAX - 1));
	assign wlen_m1    = wb_stat.wlen - 1'b1;
	assign last_row   = (row_q == wlen_m1[LEN_W-1:3]);
	assign nb         = last_row ? (NB_W'(wlen_m1[2:0]) + 1'b1) : NB_W'(CHUNK_BYTES);
	assign mask       = byte_mask(nb);
	assign row_eq     = (((wb_rd ^ tbl_row) & mask) == '0);
	assign ins_phase  = (state_q == S_INS) || (state_q == S_CP_RD) || (state_q == S_CP_EMIT);

	always_comb begin
		emit_v          = 1'b0;
		emit_req.kind   = KIND_TITLE;
		emit_req.chunk  = {{(CHUNK_W-8){1'b0}}, cur};
		emit_req.nbytes = NB_W'(1);
		emit_req.idx    = '0;
		flush           = (state_q == S_FLUSH);
		wb_cmd.wr       = 1'b0;
		wb_cmd.ch       = to_lower(cur);
		wb_cmd.clear    = (state_q == S_FIN_DONE) || (state_q == S_RESET);
		wb_cmd.row      = row_q;
		tbl_req.idx      = ins_phase ? cnt_q[IDX_W-1:0] : widx_q[IDX_W-1:0];
		tbl_req.row      = row_q;
		tbl_req.row_we   = 1'b0;
		tbl_req.row_data = wb_rd;
		tbl_req.len_we   = 1'b0;
		tbl_req.len      = wb_stat.wlen;
		case (state_q)
			S_CHAR: begin
				if (ci_q != nch_q) begin
					if (!phase_q) begin
						emit_v = title_room;
					end else if (is_word_char(cur)) begin
						wb_cmd.wr = 1'b1;
					end
				end
			end
			S_CP_EMIT: begin
				emit_v          = 1'b1;
				emit_req.kind   = KIND_WORD;
				emit_req.chunk  = wb_rd & mask;
				emit_req.nbytes = nb;
				emit_req.idx    = cnt_q[IDX_W-1:0];
				tbl_req.row_we  = emit_ready;
				tbl_req.len_we  = emit_ready && last_row;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= 1'b0;
			pc_q      <= 2'd0;
			tc_q      <= '0;
			cnt_q     <= '0;
			widx_q    <= '0;
			row_q     <= '0;
			chars_q   <= '{default: 8'h00};
			nch_q     <= 2'd0;
			ci_q      <= 2'd0;
			last_q    <= 1'b0;
			fin_end_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						chars_q <= ch_n;
						nch_q   <= n_n;
						ci_q    <= 2'd0;
						pc_q    <= pc_n;
						last_q  <= end_of_text;
						state_q <= S_CHAR;
					end
				end
				S_CHAR: begin
					if (ci_q == nch_q) begin
						state_q <= last_q ? S_END : S_FLUSH;
					end else if (!phase_q) begin
						if (!title_room || emit_ready) begin
							if (title_room) begin
								tc_q <= tc_q + 1'b1;
							end
							if (cur == BYTE_NL) begin
								phase_q <= 1'b1;
							end
							ci_q <= ci_q + 1'b1;
						end
					end else if (!is_word_char(cur) && wb_stat.nonempty) begin
						fin_end_q <= 1'b0;
						state_q   <= S_FIN;
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end
				S_END: begin
					if (phase_q && wb_stat.nonempty) begin
						fin_end_q <= 1'b1;
						state_q   <= S_FIN;
					end else begin
						state_q <= S_RESET;
					end
				end
				S_RESET: begin
					phase_q <= 1'b0;
					pc_q    <= 2'd0;
					tc_q    <= '0;
					cnt_q   <= '0;
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (flush_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					widx_q  <= '0;
					state_q <= (wb_stat.wlen == '0) ? S_FIN_DONE : S_LEN_RD;
				end
				S_FIN_DONE: begin
					if (fin_end_q) begin
						fin_end_q <= 1'b0;
						state_q   <= S_RESET;
					end else begin
						ci_q    <= ci_q + 1'b1;
						state_q <= S_CHAR;
					end
				end
				S_LEN_RD: begin
					state_q <= (widx_q == cnt_q) ? S_INS : S_LEN_CHK;
				end
				S_LEN_CHK: begin
					if (tbl_len == wb_stat.wlen) begin
						row_q   <= '0;
						state_q <= S_ROW_RD;
					end else begin
						widx_q  <= widx_q + 1'b1;
						state_q <= S_LEN_RD;
					end
				end
				S_ROW_RD: begin
					state_q <= S_ROW_CHK;
				end
				S_ROW_CHK: begin
					if (!row_eq) begin
						widx_q  <= widx_q + 1'b1;
						state_q <= S_LEN_RD;
					end else if (last_row) begin
						// already stored
						state_q <= S_FIN_DONE;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_ROW_RD;
					end
				end
				S_INS: begin
					row_q   <= '0;
					state_q <= cnt_q[IDX_W] ? S_FIN_DONE : S_CP_RD;
				end
				S_CP_RD: begin
					state_q <= S_CP_EMIT;
				end
				S_CP_EMIT: begin
					if (emit_ready) begin
						if (last_row) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_FIN_DONE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_CP_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	uwe_wbuf u_wbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (wb_cmd),
		.stat    (wb_stat),
		.rd_data (wb_rd)
	);

	uwe_table u_table (
		.clk    (clk),
		.req    (tbl_req),
		.row_rd (tbl_row),
		.len_rd (tbl_len)
	);

	uwe_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit_v      (emit_v),
		.emit_req    (emit_req),
		.emit_ready  (emit_ready),
		.flush       (flush),
		.flush_ready (flush_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.chunk       (chunk),
		.chunk_bytes (chunk_bytes),
		.word_index  (word_index),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

/* hw/rtl/uwe_emit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uwe_emit
// Output stage: holds one result back so the last one of a run can be marked,
// caps the results of a run and drives the registered output channel.
// ----------------------------------------------------------------------------
module uwe_emit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      emit_v,
	input  wire uwe_pkg::emit_req_t        emit_req,
	output logic                           emit_ready,
	input  wire logic                      flush,
	output logic                           flush_ready,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           kind,
	output logic [uwe_pkg::CHUNK_W-1:0]    chunk,
	output logic [uwe_pkg::NB_W-1:0]       chunk_bytes,
	output logic [uwe_pkg::IDX_W-1:0]      word_index,
	output logic                           last_of_run
);
	import uwe_pkg::*;

	logic            out_v_q;
	logic            last_q;
	emit_req_t       out_q;
	logic            held_v_q;
	emit_req_t       held_q;
	logic [RES_W-1:0] res_cnt_q;
	logic            out_free;
	logic            drop;
	logic            push;
	logic            move;

	assign out_free    = !out_v_q || !out_stall;
	assign drop        = (res_cnt_q == RES_W'(MAX_RES));
	assign emit_ready  = drop || !held_v_q || out_free;
	assign flush_ready = !held_v_q || out_free;
	assign push        = emit_v && !drop && (!held_v_q || out_free);
	// held result goes out when a newer one replaces it or the run closes
	assign move        = held_v_q && out_free && ((emit_v && !drop) || flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			held_v_q  <= 1'b0;
			res_cnt_q <= '0;
		end else begin
			if (move) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			if (push) begin
				held_v_q <= 1'b1;
			end else if (flush && move) begin
				held_v_q <= 1'b0;
			end
			if (flush && flush_ready) begin
				res_cnt_q <= '0;
			end else if (emit_v && emit_ready && !drop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q  <= held_q;
			last_q <= flush && !(emit_v && !drop);
		end
		if (push) begin
			held_q <= emit_req;
		end
	end

	assign out_valid   = out_v_q;
	assign kind        = out_q.kind;
	assign chunk       = out_q.chunk;
	assign chunk_bytes = out_q.nbytes;
	assign word_index  = out_q.idx;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

/* hw/rtl/uwe_wbuf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uwe_wbuf
// Current word buffer: assembles characters into 8-byte rows, drops leading
// apostrophes and tracks the trimmed length.
// ----------------------------------------------------------------------------
module uwe_wbuf (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire uwe_pkg::wb_cmd_t        cmd,
	output uwe_pkg::wb_stat_t            stat,
	output logic [uwe_pkg::CHUNK_W-1:0]  rd_data
);
	import uwe_pkg::*;

	logic [CHUNK_W-1:0] buf_mem [ROWS];
	logic [CHUNK_W-1:0] rd_q;
	logic [CHUNK_W-1:0] row_asm_q;
	logic [CHUNK_W-1:0] row_next;
	logic [LEN_W-1:0]   cur_len_q;
	logic [LEN_W-1:0]   wp_q;
	logic [LEN_W-1:0]   elen_q;
	logic               all_apos_q;
	logic               room;
	logic               store;

	assign room  = (cur_len_q != LEN_W'(WORD_LEN - 1));
	assign store = cmd.wr && room && !(all_apos_q && cmd.ch == BYTE_APOS);

	always_comb begin
		row_next = row_asm_q;
		row_next[{wp_q[2:0], 3'b000} +: 8] = cmd.ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_len_q  <= '0;
			wp_q       <= '0;
			elen_q     <= '0;
			all_apos_q <= 1'b1;
		end else if (cmd.clear) begin
			cur_len_q  <= '0;
			wp_q       <= '0;
			elen_q     <= '0;
			all_apos_q <= 1'b1;
		end else if (cmd.wr && room) begin
			cur_len_q <= cur_len_q + 1'b1;
			if (store) begin
				wp_q       <= wp_q + 1'b1;
				all_apos_q <= 1'b0;
				if (cmd.ch != BYTE_APOS) begin
					elen_q <= wp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			row_asm_q <= '0;
		end else if (store) begin
			buf_mem[wp_q[LEN_W-1:3]] <= row_next;
			row_asm_q <= (wp_q[2:0] == 3'd7) ? '0 : row_next;
		end
		rd_q <= buf_mem[cmd.row];
	end

	assign stat.nonempty = (cur_len_q != '0);
	assign stat.wlen     = elen_q;
	assign rd_data       = rd_q;

endmodule
`default_nettype wire

/* hw/rtl/uwe_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uwe_table
// Stored word table: one row memory of 8-byte chunks and one length memory,
// each single ported with registered read data.
// ----------------------------------------------------------------------------
module uwe_table (
	input  wire logic                    clk,
	input  wire uwe_pkg::tbl_req_t       req,
	output logic [uwe_pkg::CHUNK_W-1:0]  row_rd,
	output logic [uwe_pkg::LEN_W-1:0]    len_rd
);
	import uwe_pkg::*;

	logic [CHUNK_W-1:0] row_mem [STORE_ROWS];
	logic [LEN_W-1:0]   len_mem [TABLE_WORDS];
	logic [IDX_W+ROW_W-1:0] addr;

	assign addr = {req.idx, req.row};

	always_ff @(posedge clk) begin
		if (req.row_we) begin
			row_mem[addr] <= req.row_data;
		end
		row_rd <= row_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (req.len_we) begin
			len_mem[req.idx] <= req.len;
		end
		len_rd <= len_mem[req.idx];
	end

endmodule
`default_nettype wire

/* hw/rtl/uwe_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uwe_checker
// Port-level checks of the unique word extractor, bound to the top level.
// ----------------------------------------------------------------------------
module uwe_sva (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_stall,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic                    kind,
	input wire logic [uwe_pkg::CHUNK_W-1:0] chunk,
	input wire logic [uwe_pkg::NB_W-1:0]    chunk_bytes,
	input wire logic [uwe_pkg::IDX_W-1:0]   word_index,
	input wire logic                    last_of_run
);
	import uwe_pkg::*;

	// an accepted byte keeps the input stalled while it is worked off
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	// stalled result keeps valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(chunk) && $stable(kind) &&
			$stable(chunk_bytes) && $stable(word_index) && $stable(last_of_run))
		else $error("output payload changed under stall");

	// title bytes carry one character in the low byte and no index
	a_title_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TITLE |->
			chunk_bytes == NB_W'(1) && chunk[CHUNK_W-1:8] == '0 && word_index == '0)
		else $error("malformed title byte");

	// a word chunk never shows bytes beyond its count
	a_word_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_WORD |->
			chunk_bytes != '0 && chunk_bytes <= NB_W'(CHUNK_BYTES) &&
			(chunk & ~byte_mask(chunk_bytes)) == '0)
		else $error("malformed word chunk");

endmodule

bind unique_word_extractor uwe_sva u_uwe_sva (.*);
`default_nettype wire
